>>> hdl/sha_pkg.sv
// SHA-256 package: round constants, initial hash words, control types and a rotate helper.
// Used by the controller, datapath and top level of the message hasher.
`default_nettype none
package sha_pkg;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    // Command from controller to datapath
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_START,
        CMD_ROUND,
        CMD_FOLD,
        CMD_INIT
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } t_src;

    typedef struct packed {
        t_cmd        cmd;
        t_src        src;
        logic [5:0]  round;
    } t_ctrl;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[r];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> hdl/sha_datapath.sv
// SHA-256 datapath: hash words, schedule window, working variables, bit count.
// Depends on sha_pkg; driven by sha_ctrl commands.
`default_nettype none
module sha_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sha_pkg::t_ctrl     i_ctrl,
    input  wire logic [31:0]        i_word,
    input  wire logic [3:0]         i_widx,
    input  wire logic [5:0]         i_len_add,
    input  wire logic               i_len_en,
    input  wire logic [1:0]         i_part,
    output logic [63:0]             o_part
);
    import sha_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [63:0] r_len;

    logic [31:0] load_word, sched, s0, s1, t1, t2, x, y;
    logic [3:0]  ri;

    // Select the word pushed into the window
    always_comb begin
        case (i_ctrl.src)
            SRC_DATA:   load_word = i_word;
            SRC_ZERO:   load_word = '0;
            SRC_LEN_HI: load_word = r_len[63:32];
            SRC_LEN_LO: load_word = r_len[31:0];
            default:    load_word = '0;
        endcase
    end

    // Expand the schedule and form one round
    always_comb begin
        ri = i_ctrl.round[3:0];
        x  = r_w[ri + 4'd1];
        y  = r_w[ri + 4'd14];
        s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
        if (i_ctrl.round < 6'd16) sched = r_w[ri];
        else sched = r_w[ri] + s0 + r_w[ri + 4'd9] + s1;
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_const(i_ctrl.round) + sched;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.cmd == CMD_INIT) begin
            r_len <= '0;
        end else if (i_len_en) begin
            r_len <= r_len + {58'd0, i_len_add};
        end
    end

    // Hash words
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 8; i++) begin
            if (!i_rst_n || i_ctrl.cmd == CMD_INIT) begin
                r_h[i] <= init_hash(3'(i));
            end else if (i_ctrl.cmd == CMD_FOLD) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // Window and working variables
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_LOAD: r_w[i_widx] <= load_word;
            CMD_START: begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            CMD_ROUND: begin
                r_w[ri] <= sched;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            default: ;
        endcase
    end

    assign o_part = {r_h[{i_part, 1'b0}], r_h[{i_part, 1'b1}]};
endmodule
`default_nettype wire

>>> hdl/sha_ctrl.sv
// SHA-256 controller: word intake, padding sequence, rounds and digest output.
// Depends on sha_pkg; drives sha_datapath.
`default_nettype none
module sha_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [31:0]        i_data,
    input  wire logic [2:0]         i_count,
    input  wire logic               i_end,
    output sha_pkg::t_ctrl          o_ctrl,
    output logic [31:0]             o_word,
    output logic [3:0]              o_widx,
    output logic [5:0]              o_len_add,
    output logic                    o_len_en,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_part
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_START, S_ROUND, S_FOLD, S_OUT
    } t_state;

    t_state      r_state, r_ret;
    logic [3:0]  r_widx;
    logic [5:0]  r_round;
    logic [1:0]  r_part;
    logic        r_final;   // message end seen, padding in progress
    logic        r_padw;    // pad word 0x80000000 still owed
    logic        r_lenhi;   // length high word already pushed

    logic        acc;
    logic [2:0]  n;
    logic [31:0] mask, padded;

    assign acc     = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign n       = (i_count > 3'd4) ? 3'd4 : i_count;

    always_comb begin
        case (n)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'hff00_0000;
            3'd2:    mask = 32'hffff_0000;
            3'd3:    mask = 32'hffff_ff00;
            default: mask = 32'hffff_ffff;
        endcase
        padded = (i_data & mask) | (PAD_WORD >> {n, 3'b000});
    end

    // Drive datapath commands
    always_comb begin
        o_ctrl.cmd   = CMD_IDLE;
        o_ctrl.src   = SRC_DATA;
        o_ctrl.round = r_round;
        o_word       = i_data;
        o_widx       = r_widx;
        o_len_en     = 1'b0;
        o_len_add    = 6'd32;
        case (r_state)
            S_IDLE: if (acc) begin
                o_ctrl.cmd = CMD_LOAD;
                o_len_en   = 1'b1;
                if (i_end) begin
                    o_len_add = {n, 3'b000};
                    if (n != 3'd4) o_word = padded;
                end
            end
            S_PAD: begin
                o_ctrl.cmd = CMD_LOAD;
                if (r_padw) begin
                    o_word = PAD_WORD;
                end else if (r_widx == 4'd14) begin
                    o_ctrl.src = SRC_LEN_HI;
                end else if (r_widx == 4'd15 && r_lenhi) begin
                    o_ctrl.src = SRC_LEN_LO;
                end else begin
                    o_ctrl.src = SRC_ZERO;
                end
            end
            S_START: o_ctrl.cmd = CMD_START;
            S_ROUND: o_ctrl.cmd = CMD_ROUND;
            S_FOLD:  o_ctrl.cmd = CMD_FOLD;
            S_OUT: if (i_out_ready && r_part == 2'd3) o_ctrl.cmd = CMD_INIT;
            default: ;
        endcase
    end

    // Hold state, word index, round counter, part counter and padding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_widx  <= '0;
            r_round <= '0;
            r_part  <= '0;
            r_final <= 1'b0;
            r_padw  <= 1'b0;
            r_lenhi <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (acc) begin
                    r_widx  <= r_widx + 4'd1;
                    r_final <= i_end;
                    r_padw  <= i_end && (n == 3'd4);
                    r_lenhi <= 1'b0;
                    if (r_widx == 4'd15) begin
                        r_state <= S_START;
                        r_ret   <= i_end ? S_PAD : S_IDLE;
                    end else begin
                        r_state <= i_end ? S_PAD : S_IDLE;
                    end
                end
                S_PAD: begin
                    r_widx <= r_widx + 4'd1;
                    r_padw <= 1'b0;
                    if (!r_padw && r_widx == 4'd14) r_lenhi <= 1'b1;
                    if (r_widx == 4'd15) begin
                        r_state <= S_START;
                        r_ret   <= (!r_padw && r_lenhi) ? S_OUT : S_PAD;
                        if (!r_padw && r_lenhi) r_lenhi <= 1'b0;
                    end
                end
                S_START: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_state <= r_ret;
                    r_part  <= '0;
                end
                S_OUT: if (i_out_ready) begin
                    r_part <= r_part + 2'd1;
                    if (r_part == 2'd3) begin
                        r_state <= S_IDLE;
                        r_widx  <= '0;
                        r_final <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_part      = r_part;

    // Rounds only run inside a block, output only after padding
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 6'd63) |=> r_state == S_FOLD)
        else $error("round 63 not followed by fold");
    a_out_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_final)
        else $error("digest out without message end");
    a_start_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> r_widx == 4'd0)
        else $error("block started with partial window");
endmodule
`default_nettype wire

>>> hdl/sha256_message_hasher_core.sv
// SHA-256 message hasher, top level: one word per input handshake, digest as four parts.
// Each block runs the 64-round loop at one round per cycle, between start and fold.
// A final word adds padding loads (up to 16 per extra block) and four output parts.
// No new word is taken while a block is hashed, padded or sent out as digest.
// Synchronous active-low reset loads the initial hash and clears the bit counter.
`default_nettype none
module sha256_message_hasher_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_data_word,
    input  wire logic [2:0]    i_byte_count,
    input  wire logic          i_message_end,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_digest_part,
    output logic [1:0]         o_part_index,
    output logic               o_last_part
);
    import sha_pkg::*;

    t_ctrl       ctrl;
    logic [31:0] word;
    logic [3:0]  widx;
    logic [5:0]  len_add;
    logic        len_en;
    logic [1:0]  part;

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_data(i_data_word), .i_count(i_byte_count), .i_end(i_message_end),
        .o_ctrl(ctrl), .o_word(word), .o_widx(widx), .o_len_add(len_add),
        .o_len_en(len_en), .o_out_valid(o_valid), .i_out_ready(i_ready), .o_part(part)
    );

    sha_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctrl(ctrl), .i_word(word), .i_widx(widx),
        .i_len_add(len_add), .i_len_en(len_en), .i_part(part), .o_part(o_digest_part)
    );

    assign o_part_index = part;
    assign o_last_part  = (part == 2'd3);
endmodule
`default_nettype wire
